>>> hw/rtl/clsr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package clsr_pkg;

   // field widths
   localparam int SEED_W   = 32;
   localparam int SAMPLE_W = 31;
   localparam int PROD_W   = SAMPLE_W + 16;

   // first generator: 40014 mod 2^31 - 85
   localparam logic [SAMPLE_W-1:0] MOD_A  = 31'd2147483563;
   localparam logic [15:0]         MUL_A  = 16'd40014;
   localparam logic [7:0]          FOLD_A = 8'd85;

   // second generator: 40692 mod 2^31 - 249
   localparam logic [SAMPLE_W-1:0] MOD_B  = 31'd2147483399;
   localparam logic [15:0]         MUL_B  = 16'd40692;
   localparam logic [7:0]          FOLD_B = 8'd249;

   // largest sample value, one below the first modulus
   localparam logic [SAMPLE_W-1:0] TOP_OUT = 31'd2147483562;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_WAIT,
      ST_STEP,
      ST_PREP,
      ST_READ,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

>>> hw/rtl/clsr_chan_ifs.sv
`timescale 1ns / 1ps
`default_nettype none

// request channel: one word asks for one draw
interface clsr_req_if import clsr_pkg::*; ();
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink   (input valid, input restart, output ready);
endinterface

// response channel: one word per draw
interface clsr_rsp_if import clsr_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

// seed register write channel
interface clsr_csr_if import clsr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [SEED_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/combined_lcg_shuffle_rng_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Combined two-generator random number source with a shuffle table. Each
// request word returns one sample in 1..2147483562 (uniform value is
// sample / 2147483563). A draw reads the shuffle table memory in ST_READ at
// the slot chosen by the previous sample, then ST_DONE, once the response
// side keeps up, computes the new sample and writes the slot back; the next
// request is taken only then, and the following slot depends on that sample.
// Both generator products are registered every cycle from the generator
// state, so they are ready when a draw begins. A start-up run of ST_LOAD,
// then a ST_WAIT and ST_STEP pair per generator step for TABLE_SIZE +
// WARMUP_STEPS steps through the same multiplier, then ST_PREP, happens
// before the draw after reset or when restart is set, filling every table
// entry before any is read. The seed register resets to -1; write it only while the block is idle.
module combined_lcg_shuffle_rng_unit import clsr_pkg::*; #(
   parameter int TABLE_SIZE   = 32,
   parameter int WARMUP_STEPS = 8
) (
   input  wire logic   clock,
   input  wire logic   reset,
   clsr_req_if.sink    req_if,
   clsr_rsp_if.source  rsp_if,
   clsr_csr_if.sink    csr_if
);

   localparam int     IDX_W    = $clog2(TABLE_SIZE);
   localparam int     STEPS    = TABLE_SIZE + WARMUP_STEPS;
   localparam int     CNT_W    = $clog2(STEPS + 1);
   localparam longint SLOT_DIV = 64'd1 + longint'(TOP_OUT) / TABLE_SIZE;

   // fold a product back below the modulus: 2^31 is congruent to fold
   function automatic logic [SAMPLE_W-1:0] lcg_fold(
      input logic [PROD_W-1:0]   prod,
      input logic [7:0]          fold,
      input logic [SAMPLE_W-1:0] modulus
   );
      logic [SAMPLE_W:0] sum;
      sum = {1'b0, prod[SAMPLE_W-1:0]}
          + (SAMPLE_W + 1)'(prod[PROD_W-1:SAMPLE_W] * fold);
      if (sum >= {1'b0, modulus}) begin
         sum = sum - {1'b0, modulus};
      end
      return sum[SAMPLE_W-1:0];
   endfunction

   state_type state_ff, state_in;

   logic [SEED_W-1:0]   seed_ff, seed_in;
   logic [SAMPLE_W-1:0] first_ff, first_in;
   logic [SAMPLE_W-1:0] second_ff, second_in;
   logic [SAMPLE_W-1:0] last_output_ff, last_output_in;
   logic                needs_start_ff, needs_start_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [PROD_W-1:0]   prod_a_ff, prod_a_in;
   logic [PROD_W-1:0]   prod_b_ff, prod_b_in;
   logic [IDX_W-1:0]    slot_ff, slot_in;
   logic [SAMPLE_W-1:0] rdata_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0] sample_ff, sample_in;

   logic [SAMPLE_W-1:0] table_mem [TABLE_SIZE];

   logic                accept;
   logic                start_need;
   logic                done_go;
   logic                load_seed;
   logic                mem_we;
   logic [IDX_W-1:0]    mem_waddr;
   logic [SAMPLE_W-1:0] mem_wdata;
   logic [SAMPLE_W-1:0] fold_a;
   logic [SAMPLE_W-1:0] fold_b;
   logic [SAMPLE_W-1:0] start_val;
   logic [SEED_W:0]     seed_neg;
   logic [TABLE_SIZE:0] above;
   logic [IDX_W-1:0]    slot_idx;
   logic [SEED_W-1:0]   diff;
   logic [SEED_W-1:0]   diff_wrap;
   logic [SAMPLE_W-1:0] draw_y;

   // handshake decode
   always_comb begin
      done_go    = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_if.ready);
      accept     = req_if.valid && ((state_ff == ST_IDLE) || done_go);
      start_need = req_if.restart || needs_start_ff || (last_output_ff == '0);
      load_seed  = (state_ff == ST_LOAD);
   end

   assign req_if.ready  = (state_ff == ST_IDLE) || done_go;
   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.sample = sample_ff;
   assign csr_if.ready  = 1'b1;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = start_need ? ST_LOAD : ST_READ;
            end
         end
         ST_LOAD: state_in = ST_WAIT;
         ST_WAIT: state_in = ST_STEP;
         ST_STEP: state_in = (cnt_ff == '0) ? ST_PREP : ST_WAIT;
         ST_PREP: state_in = ST_READ;
         ST_READ: state_in = ST_DONE;
         ST_DONE: begin
            if (done_go) begin
               if (accept) begin
                  state_in = start_need ? ST_LOAD : ST_READ;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // start value from a negative seed as its magnitude, saturated at the top; a non-negative seed gives 1
   always_comb begin
      seed_neg = (SEED_W + 1)'(0) - {seed_ff[SEED_W-1], seed_ff};
      if (!seed_ff[SEED_W-1]) begin
         start_val = SAMPLE_W'(1);
      end else if (seed_neg > (SEED_W + 1)'(TOP_OUT)) begin
         start_val = TOP_OUT;
      end else begin
         start_val = seed_neg[SAMPLE_W-1:0];
      end
   end

   // generator products are registered from the generator state and folded here
   always_comb begin
      prod_a_in = PROD_W'(first_ff) * PROD_W'(MUL_A);
      prod_b_in = PROD_W'(second_ff) * PROD_W'(MUL_B);
      fold_a    = lcg_fold(prod_a_ff, FOLD_A, MOD_A);
      fold_b    = lcg_fold(prod_b_ff, FOLD_B, MOD_B);
   end

   // slot = last_output / SLOT_DIV through a row of constant compares
   always_comb begin
      above[0]          = 1'b1;
      above[TABLE_SIZE] = 1'b0;
      for (int k = 1; k < TABLE_SIZE; k++) begin
         above[k] = last_output_ff >= SAMPLE_W'(longint'(k) * SLOT_DIV);
      end
      slot_idx = '0;
      for (int k = 0; k < TABLE_SIZE; k++) begin
         if (above[k] && !above[k+1]) begin
            slot_idx = slot_idx | IDX_W'(k);
         end
      end
   end

   // table entry minus second generator, wrapped into 1..TOP_OUT
   always_comb begin
      diff      = SEED_W'(rdata_ff) - SEED_W'(second_ff);
      diff_wrap = SEED_W'(rdata_ff) + SEED_W'(TOP_OUT) - SEED_W'(second_ff);
      if (diff[SEED_W-1] || (diff == '0)) begin
         draw_y = diff_wrap[SAMPLE_W-1:0];
      end else begin
         draw_y = diff[SAMPLE_W-1:0];
      end
   end

   // memory write: fill during start-up, refill the drawn slot
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = slot_ff;
      mem_wdata = first_ff;
      if (state_ff == ST_STEP) begin
         mem_we    = (cnt_ff < CNT_W'(TABLE_SIZE));
         mem_waddr = cnt_ff[IDX_W-1:0];
         mem_wdata = fold_a;
      end else if (done_go) begin
         mem_we = 1'b1;
      end
   end

   // register next values
   always_comb begin
      seed_in        = csr_if.valid ? csr_if.data : seed_ff;
      first_in       = first_ff;
      second_in      = second_ff;
      last_output_in = last_output_ff;
      needs_start_in = needs_start_ff;
      cnt_in         = cnt_ff;
      slot_in        = slot_ff;
      sample_in      = sample_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_if.ready;

      if (load_seed) begin
         first_in  = start_val;
         second_in = start_val;
         cnt_in    = CNT_W'(STEPS - 1);
      end

      if (state_ff == ST_STEP) begin
         first_in = fold_a;
         cnt_in   = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            last_output_in = fold_a;
            needs_start_in = 1'b0;
         end
      end

      if (state_ff == ST_READ) begin
         first_in  = fold_a;
         second_in = fold_b;
         slot_in   = slot_idx;
      end

      if (done_go) begin
         last_output_in = draw_y;
         sample_in      = draw_y;
         rsp_valid_in   = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         seed_ff        <= '1;
         first_ff       <= '0;
         second_ff      <= '0;
         last_output_ff <= '0;
         needs_start_ff <= 1'b1;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         seed_ff        <= seed_in;
         first_ff       <= first_in;
         second_ff      <= second_in;
         last_output_ff <= last_output_in;
         needs_start_ff <= needs_start_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      cnt_ff    <= cnt_in;
      prod_a_ff <= prod_a_in;
      prod_b_ff <= prod_b_in;
      slot_ff   <= slot_in;
      sample_ff <= sample_in;
   end

   // shuffle table: read in ST_READ, written back at the same slot in ST_DONE once the response register is free,
   // so the next read always sees the write-back
   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_waddr] <= mem_wdata;
      end
      if (state_ff == ST_READ) begin
         rdata_ff <= table_mem[slot_idx];
      end
   end

   // products must match the generator state whenever they are folded
   a_prod_a_fresh: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STEP || state_ff == ST_READ)
         |-> (prod_a_ff == PROD_W'(first_ff) * PROD_W'(MUL_A)))
      else $error("first product stale at fold");

   a_prod_b_fresh: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> (prod_b_ff == PROD_W'(second_ff) * PROD_W'(MUL_B)))
      else $error("second product stale at fold");

   // no draw reads the table before start-up has filled it
   a_filled_before_draw: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> !needs_start_ff)
      else $error("draw before table fill");

   // a sample is in 1..TOP_OUT whenever the response valid rises
   a_sample_range: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> (sample_ff != '0) && (sample_ff <= TOP_OUT))
      else $error("sample out of range");

endmodule

`default_nettype wire
